// ===== hdl/csm_pkg.sv =====
// Shared types and field widths for the sparse matrix-vector block.
package csm_pkg;

    localparam int MODE_W  = 2;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int ROW_W   = 16;
    localparam int ACC_W   = 64;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD    = 2'd0,
        MODE_NONZERO = 2'd1,
        MODE_EMPTY   = 2'd2,
        MODE_RESTART = 2'd3
    } mode_t;

    // multiply stage entry
    typedef struct packed {
        logic                       valid;
        mode_t                      mode;
        logic                       row_end;
        logic                       in_range;
        logic signed [VALUE_W-1:0]  value;
    } mul_stage_t;

    // accumulate stage entry
    typedef struct packed {
        logic                       valid;
        mode_t                      mode;
        logic                       row_end;
        logic signed [ACC_W-1:0]    prod;
    } acc_stage_t;

    // closed row on its way to rounding
    typedef struct packed {
        logic                       emit;
        logic                       ovf;
        logic [ROW_W-1:0]           row;
        logic signed [ACC_W-1:0]    sum;
    } rnd_stage_t;

endpackage

// ===== hdl/csm_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
module csm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                      wdata,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ===== hdl/csr_sparse_matvec_top.sv =====
// Top level of the compressed-row sparse matrix-vector multiplier.
//
// Computes y = A*x in signed Q8.24. Beats on the slave side carry a mode in
// tuser: load a vector entry, a matrix nonzero (tlast marks the last nonzero
// of its row), an empty row, or a restart of the row count. The vector lives
// in a single-port synchronous RAM of VECTOR_DEPTH words with a registered
// read; it has no reset and must be loaded before nonzeros that use it. Each
// nonzero reads its vector entry, is multiplied in a 32x32 multiplier,
// and is added into a saturating 64-bit Q16.48 accumulator. A closed row is
// rounded half up to Q8.24, clamped to 32 bits, and sent out with its row
// number; tuser flags any saturation in that row. The block takes one beat per
// cycle unless stalled, set by one RAM access and one multiply-accumulate per
// nonzero. A closed row passes the capture, product and accumulate
// registers to the output register. Input beats keep flowing while a result
// waits for the master, unless a second closed row reaches rounding behind it.
module csr_sparse_matvec_top #(
    parameter int              VECTOR_DEPTH = 1024,
    parameter longint unsigned MAX_ROWS     = 65536
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // slave side
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [csm_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // index[9:0], value[41:10], zero pad
    input  logic [csm_pkg::MODE_W-1:0]         s_axis_tuser,  // mode[1:0]
    input  logic                               s_axis_tlast,  // row_end
    // master side
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [csm_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // row_index[15:0], y_value[47:16]
    output logic [0:0]                         m_axis_tuser   // saturated[0]
);

    import csm_pkg::*;

    localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam logic [20:0] DEPTH_LIM = 21'(VECTOR_DEPTH);
    localparam logic [32:0] ROW_LIM   = 33'(MAX_ROWS);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    // rounding limits: 2^55 - 2^23 and -2^55 - 2^23
    localparam logic signed [ACC_W-1:0] RND_HI  = 64'sh007F_FFFF_FF80_0000;
    localparam logic signed [ACC_W-1:0] RND_LO  = 64'shFF7F_FFFF_FF80_0000;
    localparam logic signed [ACC_W-1:0] RND_HALF = 64'sh0000_0000_0080_0000;

    // unpacked input fields
    mode_t                      in_mode;
    logic [INDEX_W-1:0]         in_index;
    logic signed [VALUE_W-1:0]  in_value;
    logic [AW+INDEX_W-1:0]      idx_ext;
    logic                       in_range;

    logic                       go;
    logic                       accept;

    logic [VALUE_W-1:0]         x_rdata;

    mul_stage_t                 mul_reg;
    acc_stage_t                 acc_st_reg;
    acc_stage_t                 acc_st_next;
    rnd_stage_t                 rnd_reg;
    rnd_stage_t                 rnd_next;

    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic                       ovf_reg;
    logic                       ovf_next;
    logic [ROW_W-1:0]           row_reg;
    logic [ROW_W-1:0]           row_next;

    logic signed [ACC_W-1:0]    sum;
    logic                       sum_ovf;
    logic signed [ACC_W-1:0]    sum_sat;
    logic [ROW_W-1:0]           row_inc;

    logic signed [ACC_W-1:0]    rnd_sum;
    logic [VALUE_W-1:0]         y_val;
    logic                       y_sat;

    logic                       out_valid_reg;
    logic [ROW_W-1:0]           out_row_reg;
    logic [VALUE_W-1:0]         out_y_reg;
    logic                       out_sat_reg;

    assign in_mode  = mode_t'(s_axis_tuser);
    assign in_index = s_axis_tdata[INDEX_W-1:0];
    assign in_value = s_axis_tdata[INDEX_W+VALUE_W-1:INDEX_W];
    assign idx_ext  = {{AW{1'b0}}, in_index};
    assign in_range = {11'b0, in_index} < DEPTH_LIM;

    // The whole pipe advances unless a closed row would land on a result
    // the master side has not yet taken.
    assign go            = !rnd_reg.emit || !out_valid_reg || m_axis_tready;
    assign s_axis_tready = go;
    assign accept        = s_axis_tvalid && go;

    // Vector store: write on in-range load beats, read on every advance so the read
    // data holds across a stall.
    csm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (VECTOR_DEPTH)
    ) u_vec_ram (
        .clk   (clk),
        .we    (accept && in_mode == MODE_LOAD && in_range),
        .re    (go),
        .addr  (idx_ext[AW-1:0]),
        .wdata (in_value),
        .rdata (x_rdata)
    );

    // Stage 1: capture the beat alongside the RAM read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg <= '0;
        end
        else if (go)
        begin
            mul_reg.valid    <= s_axis_tvalid;
            mul_reg.mode     <= in_mode;
            mul_reg.row_end  <= s_axis_tlast;
            mul_reg.in_range <= in_range;
            mul_reg.value    <= in_value;
        end
    end

    // Stage 2: multiply by the vector entry; an out-of-range column reads zero.
    always_comb
    begin
        acc_st_next.valid   = mul_reg.valid;
        acc_st_next.mode    = mul_reg.mode;
        acc_st_next.row_end = mul_reg.row_end;
        acc_st_next.prod    = mul_reg.in_range
                              ? ACC_W'(mul_reg.value * $signed(x_rdata))
                              : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_st_reg <= '0;
        end
        else if (go)
        begin
            acc_st_reg <= acc_st_next;
        end
    end

    // Stage 3: saturating accumulate, row close and row count.
    always_comb
    begin
        sum     = acc_reg + acc_st_reg.prod;
        sum_ovf = (acc_reg[ACC_W-1] == acc_st_reg.prod[ACC_W-1])
                  && (sum[ACC_W-1] != acc_reg[ACC_W-1]);
        sum_sat = sum_ovf ? (acc_reg[ACC_W-1] ? ACC_MIN : ACC_MAX) : sum;

        row_inc = row_reg + 1'b1;
        if ({17'b0, row_inc} >= ROW_LIM)
        begin
            row_inc = '0;
        end

        acc_next      = acc_reg;
        ovf_next      = ovf_reg;
        row_next      = row_reg;
        rnd_next.emit = 1'b0;
        rnd_next.ovf  = ovf_reg;
        rnd_next.row  = row_reg;
        rnd_next.sum  = acc_reg;

        if (acc_st_reg.valid)
        begin
            case (acc_st_reg.mode)
                MODE_NONZERO:
                begin
                    if (acc_st_reg.row_end)
                    begin
                        rnd_next.emit = 1'b1;
                        rnd_next.ovf  = ovf_reg || sum_ovf;
                        rnd_next.sum  = sum_sat;
                        acc_next      = '0;
                        ovf_next      = 1'b0;
                        row_next      = row_inc;
                    end
                    else
                    begin
                        acc_next = sum_sat;
                        ovf_next = ovf_reg || sum_ovf;
                    end
                end
                MODE_EMPTY:
                begin
                    rnd_next.emit = 1'b1;
                    acc_next      = '0;
                    ovf_next      = 1'b0;
                    row_next      = row_inc;
                end
                MODE_RESTART:
                begin
                    acc_next = '0;
                    ovf_next = 1'b0;
                    row_next = '0;
                end
                default:
                begin
                    // load beats only touch the vector store
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            ovf_reg <= 1'b0;
            row_reg <= '0;
            rnd_reg <= '0;
        end
        else if (go)
        begin
            acc_reg <= acc_next;
            ovf_reg <= ovf_next;
            row_reg <= row_next;
            rnd_reg <= rnd_next;
        end
    end

    // Stage 4: round half up to Q8.24 and clamp.
    always_comb
    begin
        rnd_sum = rnd_reg.sum + RND_HALF;
        y_sat   = rnd_reg.ovf;
        if (rnd_reg.sum >= RND_HI)
        begin
            y_val = {1'b0, {(VALUE_W-1){1'b1}}};
            y_sat = 1'b1;
        end
        else if (rnd_reg.sum < RND_LO)
        begin
            y_val = {1'b1, {(VALUE_W-1){1'b0}}};
            y_sat = 1'b1;
        end
        else
        begin
            y_val = rnd_sum[55:24];
        end
    end

    // Output register: load a closed row, drop the beat once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go && rnd_reg.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && rnd_reg.emit)
        begin
            out_row_reg <= rnd_reg.row;
            out_y_reg   <= y_val;
            out_sat_reg <= y_sat;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_y_reg, out_row_reg};
    assign m_axis_tuser  = out_sat_reg;

endmodule
